@@ hw/rtl/pwmp_pkg.sv @@
// Shared types and constants for the peer-wire message parser.
// Used by pwmp_parse, pwmp_skid and peer_wire_message_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwmp_pkg;

	localparam int unsigned PEER_ID_BYTES_DEF = 20;
	localparam int unsigned HANDSHAKE_SEEN    = 5;
	localparam int unsigned PIECE_OVERHEAD    = 9;

	localparam logic [31:0] PIECE_FIXED_BYTES = 32'(PIECE_OVERHEAD - 1);

	localparam logic [17:0] MAX_BLOCK_RESET = 18'd16384;
	localparam logic [17:0] MAX_BLOCK_LIMIT = 18'd131072;
	localparam logic [17:0] MAX_BLOCK_FLOOR = 18'd1;

	// Message ids
	localparam logic [7:0] ID_CHOKE      = 8'd0;
	localparam logic [7:0] ID_UNCHOKE    = 8'd1;
	localparam logic [7:0] ID_INTERESTED = 8'd2;
	localparam logic [7:0] ID_NOTINT     = 8'd3;
	localparam logic [7:0] ID_HAVE       = 8'd4;
	localparam logic [7:0] ID_BITFIELD   = 8'd5;
	localparam logic [7:0] ID_REQUEST    = 8'd6;
	localparam logic [7:0] ID_PIECE      = 8'd7;
	localparam logic [7:0] ID_CANCEL     = 8'd8;
	localparam logic [7:0] ID_PORT       = 8'd9;

	// Fixed field bytes per message type
	localparam logic [3:0] LEN_BYTES       = 4'd4;
	localparam logic [3:0] HAVE_BYTES      = 4'd4;
	localparam logic [3:0] PORT_BYTES      = 4'd2;
	localparam logic [3:0] INDEX_BYTES     = 4'd4;
	localparam logic [3:0] PIECE_HDR_BYTES = 4'd8;
	localparam logic [3:0] REQUEST_BYTES   = 4'd12;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_ID,
		PH_FIELDS,
		PH_STREAM,
		PH_SKIP
	} phase_t;

	typedef enum logic [3:0] {
		KIND_KEEPALIVE,
		KIND_CHOKE,
		KIND_UNCHOKE,
		KIND_INTERESTED,
		KIND_NOTINT,
		KIND_HAVE,
		KIND_BITFIELD_BYTE,
		KIND_REQUEST,
		KIND_PIECE_HDR,
		KIND_PIECE_BYTE,
		KIND_CANCEL,
		KIND_PORT,
		KIND_OVERSIZE,
		KIND_UNKNOWN_ID,
		KIND_MALFORMED
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] piece_index;
		logic [31:0] block_begin;
		logic [17:0] block_length;
		logic [7:0]  data_byte;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pwmp_parse.sv @@
// Message deframing state machine: consumes one byte per transfer and forms
// at most one result. Depends on pwmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwmp_parse import pwmp_pkg::*; #(
	parameter int unsigned PEER_ID_BYTES = PEER_ID_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        consume,
	input  wire logic [7:0]  byte_in,
	input  wire logic [17:0] max_block,
	output logic             res_valid,
	output result_t          res
);

	localparam logic [31:0] TAIL_BYTES = 32'(PEER_ID_BYTES - HANDSHAKE_SEEN);

	phase_t      phase_q, phase_d;
	logic [31:0] remaining_q, remaining_d;
	logic [7:0]  msg_id_q, msg_id_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] index_q, index_d;
	logic [31:0] begin_q, begin_d;
	logic [3:0]  cnt_q, cnt_d;

	logic [31:0] shift_nx;
	logic [3:0]  cnt_nx;
	logic [31:0] rem_dec;
	logic        rem_done;
	logic [3:0]  need;
	logic        too_short;
	logic        oversize;
	logic [17:0] req_len;
	logic        simple_id;
	logic        unknown_id;

	assign shift_nx   = {shift_q[23:0], byte_in};
	assign cnt_nx     = cnt_q + 4'd1;
	assign rem_dec    = remaining_q - 32'd1;
	assign rem_done   = (rem_dec == 32'd0);
	assign simple_id  = (byte_in <= ID_NOTINT);
	assign unknown_id = (byte_in > ID_PORT);

	always_comb begin
		case (byte_in)
			ID_HAVE:  need = HAVE_BYTES;
			ID_PIECE: need = PIECE_HDR_BYTES;
			ID_PORT:  need = PORT_BYTES;
			default:  need = REQUEST_BYTES;
		endcase
	end

	assign too_short = (rem_dec < {28'd0, need});
	// only meaningful once the piece header is known to fit
	assign oversize  = ((rem_dec - PIECE_FIXED_BYTES) > {14'd0, max_block});
	assign req_len   = (shift_nx > {14'd0, max_block}) ? max_block : shift_nx[17:0];

	// Next state
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		msg_id_d    = msg_id_q;
		shift_d     = shift_q;
		index_d     = index_q;
		begin_d     = begin_q;
		cnt_d       = cnt_q;
		if (consume) begin
			case (phase_q)
				PH_LEN: begin
					shift_d = shift_nx;
					cnt_d   = cnt_nx;
					if (cnt_nx == LEN_BYTES) begin
						cnt_d       = 4'd0;
						remaining_d = shift_nx;
						shift_d     = 32'd0;
						if (shift_nx != 32'd0) phase_d = PH_ID;
					end
				end
				PH_ID: begin
					msg_id_d    = byte_in;
					remaining_d = rem_dec;
					cnt_d       = 4'd0;
					if (simple_id) begin
						phase_d = rem_done ? PH_LEN : PH_SKIP;
					end else if (unknown_id) begin
						// skip the handshake tail whatever the length said
						remaining_d = TAIL_BYTES;
						phase_d     = (TAIL_BYTES == 32'd0) ? PH_LEN : PH_SKIP;
					end else if (byte_in == ID_BITFIELD) begin
						phase_d = rem_done ? PH_LEN : PH_STREAM;
					end else if (too_short || byte_in == ID_CANCEL || byte_in == ID_PORT ||
							(byte_in == ID_PIECE && oversize)) begin
						phase_d = rem_done ? PH_LEN : PH_SKIP;
					end else begin
						shift_d = 32'd0;
						phase_d = PH_FIELDS;
					end
				end
				PH_FIELDS: begin
					shift_d     = shift_nx;
					cnt_d       = cnt_nx;
					remaining_d = rem_dec;
					if (msg_id_q == ID_HAVE) begin
						if (cnt_nx == HAVE_BYTES) begin
							cnt_d   = 4'd0;
							phase_d = rem_done ? PH_LEN : PH_SKIP;
						end
					end else if (cnt_nx == INDEX_BYTES) begin
						index_d = shift_nx;
					end else if (msg_id_q == ID_PIECE) begin
						if (cnt_nx == PIECE_HDR_BYTES) begin
							begin_d = shift_nx;
							cnt_d   = 4'd0;
							phase_d = rem_done ? PH_LEN : PH_STREAM;
						end
					end else if (cnt_nx == PIECE_HDR_BYTES) begin
						begin_d = shift_nx;
					end else if (cnt_nx == REQUEST_BYTES) begin
						cnt_d   = 4'd0;
						phase_d = rem_done ? PH_LEN : PH_SKIP;
					end
				end
				PH_STREAM, PH_SKIP: begin
					remaining_d = rem_dec;
					if (rem_done) phase_d = PH_LEN;
				end
				default: begin
					phase_d     = PH_LEN;
					remaining_d = 32'd0;
					msg_id_d    = 8'd0;
					shift_d     = 32'd0;
					index_d     = 32'd0;
					begin_d     = 32'd0;
					cnt_d       = 4'd0;
				end
			endcase
		end
	end

	// Result
	always_comb begin
		res_valid        = 1'b0;
		res.kind         = KIND_KEEPALIVE;
		res.piece_index  = 32'd0;
		res.block_begin  = 32'd0;
		res.block_length = 18'd0;
		res.data_byte    = 8'd0;
		res.last         = 1'b1;
		if (consume) begin
			case (phase_q)
				PH_LEN: begin
					res_valid = (cnt_nx == LEN_BYTES) && (shift_nx == 32'd0);
				end
				PH_ID: begin
					res_valid = 1'b1;
					if (simple_id) begin
						case (byte_in)
							ID_CHOKE:      res.kind = KIND_CHOKE;
							ID_UNCHOKE:    res.kind = KIND_UNCHOKE;
							ID_INTERESTED: res.kind = KIND_INTERESTED;
							default:       res.kind = KIND_NOTINT;
						endcase
					end else if (unknown_id) begin
						res.kind = KIND_UNKNOWN_ID;
					end else if (byte_in == ID_BITFIELD) begin
						res_valid = 1'b0;
					end else if (too_short) begin
						res.kind = KIND_MALFORMED;
					end else if (byte_in == ID_CANCEL) begin
						res.kind = KIND_CANCEL;
					end else if (byte_in == ID_PORT) begin
						res.kind = KIND_PORT;
					end else if (byte_in == ID_PIECE && oversize) begin
						res.kind = KIND_OVERSIZE;
					end else begin
						res_valid = 1'b0;
					end
				end
				PH_FIELDS: begin
					if (msg_id_q == ID_HAVE) begin
						res_valid       = (cnt_nx == HAVE_BYTES);
						res.kind        = KIND_HAVE;
						res.piece_index = shift_nx;
					end else if (msg_id_q == ID_PIECE) begin
						res_valid        = (cnt_nx == PIECE_HDR_BYTES);
						res.kind         = KIND_PIECE_HDR;
						res.piece_index  = index_q;
						res.block_begin  = shift_nx;
						res.block_length = rem_dec[17:0];
						res.last         = rem_done;
					end else begin
						res_valid        = (cnt_nx == REQUEST_BYTES);
						res.kind         = KIND_REQUEST;
						res.piece_index  = index_q;
						res.block_begin  = begin_q;
						res.block_length = req_len;
					end
				end
				PH_STREAM: begin
					res_valid     = 1'b1;
					res.kind      = (msg_id_q == ID_BITFIELD) ? KIND_BITFIELD_BYTE
						: KIND_PIECE_BYTE;
					res.data_byte = byte_in;
					res.last      = rem_done;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			remaining_q <= 32'd0;
			msg_id_q    <= 8'd0;
			shift_q     <= 32'd0;
			index_q     <= 32'd0;
			begin_q     <= 32'd0;
			cnt_q       <= 4'd0;
		end else begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			msg_id_q    <= msg_id_d;
			shift_q     <= shift_d;
			index_q     <= index_d;
			begin_q     <= begin_d;
			cnt_q       <= cnt_d;
		end
	end

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEN |-> cnt_q < LEN_BYTES)
		else $error("length prefix byte count out of range");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STREAM || phase_q == PH_SKIP || phase_q == PH_ID)
			|-> remaining_q != 32'd0)
		else $error("body phase with no bytes left");

	a_fields_id: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIELDS
			|-> (msg_id_q == ID_HAVE || msg_id_q == ID_REQUEST || msg_id_q == ID_PIECE))
		else $error("field collection for a message without fields");

	a_stream_id: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STREAM |-> (msg_id_q == ID_BITFIELD || msg_id_q == ID_PIECE))
		else $error("streaming payload of a message without one");

endmodule

`default_nettype wire

@@ hw/rtl/pwmp_skid.sv @@
// Two-slot result buffer: output register plus skid slot, so the parser
// keeps taking bytes while a result waits. Depends on pwmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwmp_skid import pwmp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    out_stall,
	output logic         out_valid,
	output result_t      out_data,
	output logic         full
);

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// no push while full; drain skid into output on transfer
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/peer_wire_message_parser.sv @@
// Peer-wire message parser: takes one received byte per transfer and deframes
// length-prefixed messages into event, header, payload-byte and error results,
// at most one result per byte. A byte is registered in the input stage, decoded
// combinationally when the parser consumes it, and its result is registered into
// a two-slot output buffer (output register plus skid slot). Throughput is one
// byte per cycle; in_stall rises only when both output slots hold results
// that the consumer has not taken. max_block may be written only while the block
// is idle; 0 acts as 1 and values above 131072 act as 131072. Depends on
// pwmp_pkg, pwmp_parse and pwmp_skid.
`timescale 1ns / 1ps
`default_nettype none

module peer_wire_message_parser import pwmp_pkg::*; #(
	parameter int unsigned PEER_ID_BYTES = PEER_ID_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [17:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       kind,
	output logic [31:0]      piece_index,
	output logic [31:0]      block_begin,
	output logic [17:0]      block_length,
	output logic [7:0]       data_byte,
	output logic             last
);

	logic [17:0] max_block_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        consume;
	logic        buf_full;
	logic        res_valid;
	result_t     res;
	result_t     out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_block_q <= MAX_BLOCK_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == 18'd0) begin
				max_block_q <= MAX_BLOCK_FLOOR;
			end else if (cfg_wr_data > MAX_BLOCK_LIMIT) begin
				max_block_q <= MAX_BLOCK_LIMIT;
			end else begin
				max_block_q <= cfg_wr_data;
			end
		end
	end

	// hold the input stage only when the result buffer cannot take more
	assign in_stall = valid_s1 && buf_full;
	assign consume  = valid_s1 && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= rx_byte;
	end

	pwmp_parse #(
		.PEER_ID_BYTES(PEER_ID_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.consume   (consume),
		.byte_in   (byte_s1),
		.max_block (max_block_q),
		.res_valid (res_valid),
		.res       (res)
	);

	pwmp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	assign kind         = out_res.kind;
	assign piece_index  = out_res.piece_index;
	assign block_begin  = out_res.block_begin;
	assign block_length = out_res.block_length;
	assign data_byte    = out_res.data_byte;
	assign last         = out_res.last;

endmodule

`default_nettype wire
